// ===== design/fltpm_pkg.sv =====
// Shared types and codes for the four-level page table manager.
// Holds the compact table entry format and the command and status codes.
// No dependencies.
package fltpm_pkg;

   // Command codes on the request channel.
   localparam logic [1:0] CMD_MAP       = 2'd0;
   localparam logic [1:0] CMD_UNMAP     = 2'd1;
   localparam logic [1:0] CMD_TRANSLATE = 2'd2;
   localparam logic [1:0] CMD_NOP       = 2'd3;

   // Status codes on the response channel.
   localparam logic [1:0] STATUS_DONE      = 2'd0;
   localparam logic [1:0] STATUS_EXHAUSTED = 2'd1;
   localparam logic [1:0] STATUS_UNMAPPED  = 2'd2;

   localparam int unsigned IDX_WIDTH   = 9;
   localparam int unsigned FRAME_WIDTH = 40;
   localparam int unsigned OFF_WIDTH   = 12;

   // Only the bits of a 64-bit entry that can ever be nonzero are kept.
   typedef struct packed {
      logic                   no_exec;
      logic [FRAME_WIDTH-1:0] frame;
      logic                   user;
      logic                   writ;
      logic                   present;
   } entry_type;

endpackage

// ===== design/four_level_page_table_manager.sv =====
// Four-level page table manager: table store, walk sequencer and result register.
// Depends on fltpm_pkg for the entry format and the command and status codes.
//
// Usage:
//   csr_* writes root_table_base (bits 51..12 kept); csr_ready is always high.
//   Write it only while no request is in flight.
//   req_* carries one word per map, unmap or translate; rsp_* returns one word
//   (status, translated_addr) for each request, in order.
// Walk:
//   The walk issues one table read per level through the single store port and
//   passes through a read state and an evaluate state on each level visited (up
//   to 4 levels), then a finish state posts the result to rsp_*; a no-op goes
//   straight to the finish state.
//   req_ready is high only while the sequencer is idle, one request at a time,
//   so a new request is taken only after the last one has posted its result.
// Reset:
//   After reset the sequencer sweeps the store to zero, one entry per cycle,
//   all TABLE_COUNT * 512 entries, and takes no request meanwhile.
// Stalls:
//   A result waiting on rsp_ready does not block the next request; the walk
//   holds its own result only if the output register is still full at the end.
module four_level_page_table_manager #(
   parameter int unsigned TABLE_COUNT = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [51:0] csr_root_table_base,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [47:0] req_virt_addr,
   input  logic [51:0] req_phys_addr,
   input  logic        req_writable,
   input  logic        req_user_access,
   input  logic        req_executable,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [51:0] rsp_translated_addr
);
   import fltpm_pkg::*;

   localparam int unsigned TIW   = $clog2(TABLE_COUNT);
   localparam int unsigned NFW   = $clog2(TABLE_COUNT + 1);
   localparam int unsigned AW    = TIW + IDX_WIDTH;
   localparam int unsigned DEPTH = TABLE_COUNT * 512;

   typedef enum logic [4:0] {
      ST_CLEAR  = 5'b00001,
      ST_IDLE   = 5'b00010,
      ST_READ   = 5'b00100,
      ST_EVAL   = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   entry_type table_store [DEPTH];

   state_type              state_ff, state_in;
   logic [AW-1:0]          clr_cnt_ff, clr_cnt_in;
   logic [NFW-1:0]         next_free_ff, next_free_in;
   logic [FRAME_WIDTH-1:0] base_ff, base_in;
   logic [1:0]             level_ff, level_in;
   logic [TIW-1:0]         cur_ff, cur_in;
   logic [1:0]             cmd_ff, cmd_in;
   logic [47:0]            va_ff, va_in;
   logic [FRAME_WIDTH-1:0] pa_ff, pa_in;
   logic                   writ_ff, writ_in;
   logic                   user_ff, user_in;
   logic                   exec_ff, exec_in;
   logic [1:0]             status_ff, status_in;
   logic [51:0]            result_ff, result_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [1:0]             rsp_status_ff, rsp_status_in;
   logic [51:0]            rsp_addr_ff, rsp_addr_in;
   entry_type              rd_data_ff;

   logic                   mem_we;
   logic [AW-1:0]          mem_addr;
   entry_type              mem_wdata;
   logic [IDX_WIDTH-1:0]   idx;
   logic [FRAME_WIDTH-1:0] rel;
   logic                   usable;
   logic [FRAME_WIDTH-1:0] new_frame;
   logic                   pool_full;

   assign csr_ready           = 1'b1;
   assign req_ready           = (state_ff == ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_translated_addr = rsp_addr_ff;

   always_comb begin
      case (level_ff)
         2'd0:    idx = va_ff[47:39];
         2'd1:    idx = va_ff[38:30];
         2'd2:    idx = va_ff[29:21];
         default: idx = va_ff[20:12];
      endcase
   end

   // A directory entry is usable only if it points into the allocated part of the pool.
   assign rel       = rd_data_ff.frame - base_ff;
   assign usable    = rel < FRAME_WIDTH'(next_free_ff);
   assign new_frame = base_ff + FRAME_WIDTH'(next_free_ff);
   assign pool_full = next_free_ff >= NFW'(TABLE_COUNT);

   always_comb begin
      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      next_free_in  = next_free_ff;
      base_in       = base_ff;
      level_in      = level_ff;
      cur_in        = cur_ff;
      cmd_in        = cmd_ff;
      va_in         = va_ff;
      pa_in         = pa_ff;
      writ_in       = writ_ff;
      user_in       = user_ff;
      exec_in       = exec_ff;
      status_in     = status_ff;
      result_in     = result_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      mem_we        = 1'b0;
      mem_addr      = {cur_ff, idx};
      mem_wdata     = '0;

      if (csr_valid) begin
         base_in = csr_root_table_base[51:12];
      end

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we     = 1'b1;
            mem_addr   = clr_cnt_ff;
            clr_cnt_in = clr_cnt_ff + AW'(1);
            if (clr_cnt_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in    = req_command;
               va_in     = req_virt_addr;
               pa_in     = req_phys_addr[51:12];
               writ_in   = req_writable;
               user_in   = req_user_access;
               exec_in   = req_executable;
               level_in  = 2'd0;
               cur_in    = '0;
               status_in = STATUS_DONE;
               result_in = '0;
               state_in  = (req_command == CMD_NOP) ? ST_FINISH : ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (level_ff != 2'd3) begin
               if (rd_data_ff.present) begin
                  if (usable) begin
                     cur_in   = rel[TIW-1:0];
                     level_in = level_ff + 2'd1;
                     state_in = ST_READ;
                  end else begin
                     status_in = (cmd_ff == CMD_MAP) ? STATUS_EXHAUSTED : STATUS_UNMAPPED;
                     state_in  = ST_FINISH;
                  end
               end else if (cmd_ff != CMD_MAP) begin
                  status_in = STATUS_UNMAPPED;
                  state_in  = ST_FINISH;
               end else if (pool_full) begin
                  status_in = STATUS_EXHAUSTED;
                  state_in  = ST_FINISH;
               end else begin
                  // Hand out the next table and link it from this directory slot.
                  mem_we            = 1'b1;
                  mem_wdata.frame   = new_frame;
                  mem_wdata.present = 1'b1;
                  mem_wdata.writ    = 1'b1;
                  mem_wdata.user    = user_ff;
                  cur_in            = next_free_ff[TIW-1:0];
                  next_free_in      = next_free_ff + NFW'(1);
                  level_in          = level_ff + 2'd1;
                  state_in          = ST_READ;
               end
            end else begin
               state_in = ST_FINISH;
               case (cmd_ff)
                  CMD_MAP: begin
                     mem_we            = 1'b1;
                     mem_wdata.frame   = pa_ff;
                     mem_wdata.present = 1'b1;
                     mem_wdata.writ    = writ_ff;
                     mem_wdata.user    = user_ff;
                     mem_wdata.no_exec = !exec_ff;
                  end
                  CMD_UNMAP: begin
                     mem_we    = 1'b1;
                     status_in = rd_data_ff.present ? STATUS_DONE : STATUS_UNMAPPED;
                  end
                  default: begin
                     if (rd_data_ff.present) begin
                        result_in = {rd_data_ff.frame, va_ff[OFF_WIDTH-1:0]};
                     end else begin
                        status_in = STATUS_UNMAPPED;
                     end
                  end
               endcase
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_addr_in   = result_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_store[mem_addr] <= mem_wdata;
      end
      rd_data_ff <= table_store[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         next_free_ff <= NFW'(1);
         base_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         next_free_ff <= next_free_in;
         base_ff      <= base_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      level_ff      <= level_in;
      cur_ff        <= cur_in;
      cmd_ff        <= cmd_in;
      va_ff         <= va_in;
      pa_ff         <= pa_in;
      writ_ff       <= writ_in;
      user_ff       <= user_in;
      exec_ff       <= exec_in;
      status_ff     <= status_in;
      result_ff     <= result_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
   end

endmodule
